@@ hdl/qoid_pkg.sv @@
// Shared types, constants and helpers for the QOI image decoder.
package qoid_pkg;

    localparam logic [31:0] MAGIC_QOIF  = 32'h716f6966;
    localparam logic [58:0] PIXEL_LIMIT = 59'd400000000;

    localparam logic [7:0] OP_RGB  = 8'hfe;
    localparam logic [7:0] OP_RGBA = 8'hff;
    localparam logic [1:0] TAG_INDEX = 2'b00;
    localparam logic [1:0] TAG_DIFF  = 2'b01;
    localparam logic [1:0] TAG_LUMA  = 2'b10;

    localparam logic [3:0] HDR_MAGIC_END  = 4'd4;
    localparam logic [3:0] HDR_WIDTH_END  = 4'd8;
    localparam logic [3:0] HDR_HEIGHT_END = 4'd12;
    localparam logic [3:0] HDR_CHAN       = 4'd12;
    localparam logic [3:0] HDR_LAST       = 4'd13;

    localparam logic [2:0] CH_RGB = 3'd3;
    localparam logic [2:0] CH_RESET = 3'd4;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DECODE,
        PH_IDLE
    } phase_t;

    typedef enum logic [2:0] {
        CMD_HEADER,
        CMD_RGB,
        CMD_RGBA,
        CMD_INDEX,
        CMD_DIFF,
        CMD_LUMA,
        CMD_RUN
    } cmd_op_t;

    typedef enum logic [1:0] {
        BK_READY,
        BK_FETCH,
        BK_EMIT
    } bk_state_t;

    // One decoded operation handed from the front end to the back end.
    typedef struct packed {
        cmd_op_t     op;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  code;
        logic [7:0]  operand;
        logic [5:0]  count;
        logic        eoi;
        logic        hdr_ok;
        logic [31:0] width;
        logic [31:0] height;
        logic [7:0]  channels;
        logic [7:0]  colorspace;
    } cmd_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last_of_run;
        logic        end_of_image;
        logic        header_ok;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [7:0]  image_channels;
        logic [7:0]  color_space;
    } res_t;

    function automatic logic [5:0] px_hash(input logic [31:0] px);
        logic [5:0] r;
        logic [5:0] g;
        logic [5:0] b;
        logic [5:0] a;
        r = px[29:24];
        g = px[21:16];
        b = px[13:8];
        a = px[5:0];
        return 6'(r * 6'd3 + g * 6'd5 + b * 6'd7 + a * 6'd11);
    endfunction

endpackage

@@ hdl/qoid_front.sv @@
// Front end: header collection and check, op parsing, pixel budget.
module qoid_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          data_byte,
    input  logic                start_of_file,
    input  logic                fifo_full,
    output logic                fifo_push,
    output qoid_pkg::cmd_t      fifo_cmd
);

    qoid_pkg::phase_t phase_reg, phase_next, ph_eff;
    logic [3:0]  hc_reg, hc_next, hc_eff;
    logic [31:0] magic_reg, magic_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [7:0]  chan_reg, chan_next;
    logic [58:0] prod_reg, prod_next;
    logic        big_reg, big_next;
    logic [7:0]  pend_reg, pend_next, pend_eff;
    logic [1:0]  opc_reg, opc_next;
    logic [7:0]  opr_reg, opr_next;
    logic [7:0]  opg_reg, opg_next;
    logic [7:0]  opb_reg, opb_next;
    logic [28:0] left_reg, left_next;

    logic        accept;
    logic [29:0] h_inc;
    logic [58:0] prod_calc;
    logic        hdr_ok;
    logic        pix_push;
    logic [6:0]  run_n;
    logic [6:0]  take;
    logic [28:0] left_after;
    logic [1:0]  last_opc;

    assign full   = fifo_full;
    assign accept = push && !fifo_full;

    assign ph_eff   = start_of_file ? qoid_pkg::PH_HEADER : phase_reg;
    assign hc_eff   = start_of_file ? 4'd0 : hc_reg;
    assign pend_eff = start_of_file ? 8'd0 : pend_reg;

    // (h+1)*w <= limit is the same test as h < limit/w; the upper bits are screened separately
    assign h_inc     = {1'b0, height_reg[28:0]} + 30'd1;
    assign prod_calc = h_inc * width_reg[28:0];

    assign hdr_ok = (magic_reg == qoid_pkg::MAGIC_QOIF) && (width_reg != 32'd0)
                 && (height_reg != 32'd0) && (chan_reg >= 8'd3) && (chan_reg <= 8'd4)
                 && (data_byte <= 8'd1) && !big_reg && (prod_reg <= qoid_pkg::PIXEL_LIMIT);

    assign last_opc   = (pend_eff == qoid_pkg::OP_RGBA) ? 2'd3 : 2'd2;
    assign take       = (left_reg < 29'(run_n)) ? left_reg[6:0] : run_n;
    assign left_after = left_reg - 29'(take);

    always_comb
    begin
        phase_next  = phase_reg;
        hc_next     = hc_reg;
        magic_next  = magic_reg;
        width_next  = width_reg;
        height_next = height_reg;
        chan_next   = chan_reg;
        prod_next   = prod_reg;
        big_next    = big_reg;
        pend_next   = pend_reg;
        opc_next    = opc_reg;
        opr_next    = opr_reg;
        opg_next    = opg_reg;
        opb_next    = opb_reg;
        left_next   = left_reg;
        fifo_push   = 1'b0;
        fifo_cmd    = '0;
        pix_push    = 1'b0;
        run_n       = 7'd1;

        if (accept)
        begin
            if (start_of_file)
            begin
                phase_next = qoid_pkg::PH_HEADER;
                pend_next  = 8'd0;
                opc_next   = 2'd0;
            end
            case (ph_eff)
                qoid_pkg::PH_HEADER:
                begin
                    if (hc_eff < qoid_pkg::HDR_MAGIC_END)
                        magic_next = {magic_reg[23:0], data_byte};
                    else if (hc_eff < qoid_pkg::HDR_WIDTH_END)
                        width_next = {width_reg[23:0], data_byte};
                    else if (hc_eff < qoid_pkg::HDR_HEIGHT_END)
                        height_next = {height_reg[23:0], data_byte};
                    else if (hc_eff == qoid_pkg::HDR_CHAN)
                    begin
                        chan_next = data_byte;
                        prod_next = prod_calc;
                        big_next  = (|width_reg[31:29]) || (|height_reg[31:29]);
                    end
                    hc_next = hc_eff + 4'd1;
                    if (hc_eff == qoid_pkg::HDR_LAST)
                    begin
                        fifo_push           = 1'b1;
                        fifo_cmd.op         = qoid_pkg::CMD_HEADER;
                        fifo_cmd.count      = 6'd1;
                        fifo_cmd.hdr_ok     = hdr_ok;
                        fifo_cmd.width      = width_reg;
                        fifo_cmd.height     = height_reg;
                        fifo_cmd.channels   = chan_reg;
                        fifo_cmd.colorspace = data_byte;
                        if (hdr_ok)
                        begin
                            phase_next = qoid_pkg::PH_DECODE;
                            left_next  = prod_reg[28:0] - width_reg[28:0];
                        end
                        else
                            phase_next = qoid_pkg::PH_IDLE;
                    end
                end
                qoid_pkg::PH_DECODE:
                begin
                    fifo_cmd.code = data_byte;
                    if (pend_eff == qoid_pkg::OP_RGB || pend_eff == qoid_pkg::OP_RGBA)
                    begin
                        case (opc_reg)
                            2'd0:    opr_next = data_byte;
                            2'd1:    opg_next = data_byte;
                            2'd2:    opb_next = data_byte;
                            default: ;
                        endcase
                        opc_next = opc_reg + 2'd1;
                        if (opc_reg == last_opc)
                        begin
                            pix_push       = 1'b1;
                            pend_next      = 8'd0;
                            opc_next       = 2'd0;
                            fifo_cmd.red   = opr_reg;
                            fifo_cmd.green = opg_reg;
                            if (pend_eff == qoid_pkg::OP_RGBA)
                            begin
                                fifo_cmd.op    = qoid_pkg::CMD_RGBA;
                                fifo_cmd.blue  = opb_reg;
                                fifo_cmd.alpha = data_byte;
                            end
                            else
                            begin
                                fifo_cmd.op   = qoid_pkg::CMD_RGB;
                                fifo_cmd.blue = data_byte;
                            end
                        end
                    end
                    else if (pend_eff != 8'd0)
                    begin
                        pix_push         = 1'b1;
                        pend_next        = 8'd0;
                        fifo_cmd.op      = qoid_pkg::CMD_LUMA;
                        fifo_cmd.code    = pend_eff;
                        fifo_cmd.operand = data_byte;
                    end
                    else if (data_byte == qoid_pkg::OP_RGB || data_byte == qoid_pkg::OP_RGBA)
                    begin
                        pend_next = data_byte;
                        opc_next  = 2'd0;
                    end
                    else
                    begin
                        case (data_byte[7:6])
                            qoid_pkg::TAG_INDEX:
                            begin
                                pix_push    = 1'b1;
                                fifo_cmd.op = qoid_pkg::CMD_INDEX;
                            end
                            qoid_pkg::TAG_DIFF:
                            begin
                                pix_push    = 1'b1;
                                fifo_cmd.op = qoid_pkg::CMD_DIFF;
                            end
                            qoid_pkg::TAG_LUMA:
                            begin
                                pend_next = data_byte;
                            end
                            default:
                            begin
                                pix_push    = 1'b1;
                                fifo_cmd.op = qoid_pkg::CMD_RUN;
                                run_n       = {1'b0, data_byte[5:0]} + 7'd1;
                            end
                        endcase
                    end
                    if (pix_push)
                    begin
                        fifo_push      = 1'b1;
                        fifo_cmd.count = take[5:0];
                        fifo_cmd.eoi   = (left_after == 29'd0);
                        left_next      = left_after;
                        if (left_after == 29'd0)
                            phase_next = qoid_pkg::PH_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= qoid_pkg::PH_HEADER;
            hc_reg     <= 4'd0;
            magic_reg  <= 32'd0;
            width_reg  <= 32'd0;
            height_reg <= 32'd0;
            chan_reg   <= 8'd0;
            prod_reg   <= 59'd0;
            big_reg    <= 1'b0;
            pend_reg   <= 8'd0;
            opc_reg    <= 2'd0;
            left_reg   <= 29'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hc_reg     <= hc_next;
            magic_reg  <= magic_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            chan_reg   <= chan_next;
            prod_reg   <= prod_next;
            big_reg    <= big_next;
            pend_reg   <= pend_next;
            opc_reg    <= opc_next;
            left_reg   <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opr_reg <= opr_next;
        opg_reg <= opg_next;
        opb_reg <= opb_next;
    end

    a_decode_has_budget: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == qoid_pkg::PH_DECODE |-> left_reg != 29'd0)
        else $error("decode phase with no pixels left");

    a_push_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> fifo_cmd.count != 6'd0)
        else $error("command with zero pixel count");

endmodule

@@ hdl/qoid_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
module qoid_cmd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  qoid_pkg::cmd_t      wr_cmd,
    output logic                fifo_full,
    input  logic                rd_en,
    output qoid_pkg::cmd_t      rd_cmd,
    output logic                fifo_empty
);

    qoid_pkg::cmd_t mem [qoid_pkg::FIFO_DEPTH];
    logic [qoid_pkg::FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [qoid_pkg::FIFO_AW:0]   cnt_reg, cnt_next;
    logic do_wr;
    logic do_rd;

    assign fifo_full  = (cnt_reg == (qoid_pkg::FIFO_AW+1)'(qoid_pkg::FIFO_DEPTH));
    assign fifo_empty = (cnt_reg == '0);
    assign do_wr      = wr_en && !fifo_full;
    assign do_rd      = rd_en && !fifo_empty;
    assign rd_cmd     = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_cmd;
    end

endmodule

@@ hdl/qoid_back.sv @@
// Back end: pixel reconstruction, color index and result register.
module qoid_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          out_channels,
    input  logic                fifo_empty,
    input  qoid_pkg::cmd_t      fifo_cmd,
    output logic                fifo_pop,
    input  logic                pop,
    output logic                empty,
    output qoid_pkg::res_t      res
);

    qoid_pkg::bk_state_t state_reg, state_next;
    qoid_pkg::cmd_t      cur_reg, cur_next;
    qoid_pkg::res_t      out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         prev_reg, prev_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [63:0]         valid_reg, valid_next;

    logic [31:0] mem [64];
    logic [31:0] rd_q;
    logic        mem_we;
    logic [5:0]  wr_addr;

    logic [7:0]  pr, pg, pb, pa;
    logic [7:0]  vg;
    logic [31:0] new_px;
    logic        out_free;

    assign pr = prev_reg[31:24];
    assign pg = prev_reg[23:16];
    assign pb = prev_reg[15:8];
    assign pa = prev_reg[7:0];
    assign vg = {2'b00, fifo_cmd.code[5:0]} - 8'd32;

    assign out_free = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;
    assign res      = out_reg;
    assign wr_addr  = qoid_pkg::px_hash(prev_reg);

    always_comb
    begin
        case (fifo_cmd.op)
            qoid_pkg::CMD_RGB:  new_px = {fifo_cmd.red, fifo_cmd.green, fifo_cmd.blue, pa};
            qoid_pkg::CMD_RGBA: new_px = {fifo_cmd.red, fifo_cmd.green, fifo_cmd.blue,
                                          fifo_cmd.alpha};
            qoid_pkg::CMD_DIFF:
                new_px = {pr + {6'd0, fifo_cmd.code[5:4]} - 8'd2,
                          pg + {6'd0, fifo_cmd.code[3:2]} - 8'd2,
                          pb + {6'd0, fifo_cmd.code[1:0]} - 8'd2, pa};
            qoid_pkg::CMD_LUMA:
                new_px = {pr + vg - 8'd8 + {4'd0, fifo_cmd.operand[7:4]},
                          pg + vg,
                          pb + vg - 8'd8 + {4'd0, fifo_cmd.operand[3:0]}, pa};
            default:            new_px = prev_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qoid_pkg::BK_READY:
            begin
                if (!fifo_empty)
                    state_next = (fifo_cmd.op == qoid_pkg::CMD_INDEX) ? qoid_pkg::BK_FETCH
                                                                      : qoid_pkg::BK_EMIT;
            end
            qoid_pkg::BK_FETCH: state_next = qoid_pkg::BK_EMIT;
            qoid_pkg::BK_EMIT:
            begin
                if (out_free && cnt_reg == 6'd1)
                    state_next = qoid_pkg::BK_READY;
            end
            default: state_next = qoid_pkg::BK_READY;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        fifo_pop       = 1'b0;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        cnt_next       = cnt_reg;
        valid_next     = valid_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        mem_we         = 1'b0;
        case (state_reg)
            qoid_pkg::BK_READY:
            begin
                if (!fifo_empty)
                begin
                    fifo_pop = 1'b1;
                    cur_next = fifo_cmd;
                    cnt_next = fifo_cmd.count;
                    if (fifo_cmd.op == qoid_pkg::CMD_HEADER)
                    begin
                        prev_next  = 32'h000000ff;
                        valid_next = '0;
                    end
                    else
                        prev_next = new_px;
                end
            end
            qoid_pkg::BK_FETCH:
            begin
                prev_next = valid_reg[cur_reg.code[5:0]] ? rd_q : 32'd0;
            end
            qoid_pkg::BK_EMIT:
            begin
                if (cur_reg.op != qoid_pkg::CMD_HEADER)
                begin
                    mem_we              = 1'b1;
                    valid_next[wr_addr] = 1'b1;
                end
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    cnt_next       = cnt_reg - 6'd1;
                    out_next       = '0;
                    if (cur_reg.op == qoid_pkg::CMD_HEADER)
                    begin
                        out_next.kind           = 1'b1;
                        out_next.header_ok      = cur_reg.hdr_ok;
                        out_next.image_width    = cur_reg.width;
                        out_next.image_height   = cur_reg.height;
                        out_next.image_channels = cur_reg.channels;
                        out_next.color_space    = cur_reg.colorspace;
                    end
                    else
                    begin
                        out_next.red          = pr;
                        out_next.green        = pg;
                        out_next.blue         = pb;
                        out_next.alpha        = (out_channels == qoid_pkg::CH_RGB) ? 8'd0 : pa;
                        out_next.last_of_run  = (cnt_reg == 6'd1);
                        out_next.end_of_image = (cnt_reg == 6'd1) && cur_reg.eoi;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qoid_pkg::BK_READY;
            out_valid_reg <= 1'b0;
            prev_reg      <= 32'h000000ff;
            cnt_reg       <= 6'd0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            prev_reg      <= prev_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    // color index: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= prev_reg;
        rd_q <= mem[fifo_cmd.code[5:0]];
    end

    a_fetch_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == qoid_pkg::BK_FETCH |=> state_reg == qoid_pkg::BK_EMIT)
        else $error("index fetch not followed by emit");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == qoid_pkg::BK_EMIT |-> cnt_reg != 6'd0)
        else $error("emit with zero count");

    a_header_single: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == qoid_pkg::BK_EMIT && cur_reg.op == qoid_pkg::CMD_HEADER
        |-> cnt_reg == 6'd1)
        else $error("header command with more than one result");

endmodule

@@ hdl/qoi_image_decoder.sv @@
// Top level of the QOI image decoder.
// Input side is a queue: a byte is taken at a clock edge with push high and
// full low; start_of_file marks the first header byte of a file and restarts
// decoding. Result side is a queue as well: the oldest result sits on the
// result ports while empty is low and is taken at an edge with pop high.
// The 14th header byte yields one header result (kind 1); after a good header
// every pixel op yields its pixels (kind 0) until width*height are out.
// A pixel op is parsed by the front end combinationally as its last byte is
// taken; the back end then picks it up from the command queue (an index
// lookup passes through the FETCH state, which reads the index memory) and
// emits one pixel per cycle into the result register while it is free or popped.
// A two-entry command queue lets header and operand bytes flow in while the
// back end emits; when the result is not popped the back end holds and the
// input side fills up and raises full.
// Reset clears all control state and sets out_channels to 4; the 64-entry
// color index is tracked by valid bits that each header clears.
// cfg_wr_en/cfg_wr_data write out_channels (3 zeroes the alpha field).
module qoi_image_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    output logic        empty,
    input  logic        pop,
    output logic        kind,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic        last_of_run,
    output logic        end_of_image,
    output logic        header_ok,
    output logic [31:0] image_width,
    output logic [31:0] image_height,
    output logic [7:0]  image_channels,
    output logic [7:0]  color_space,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data
);

    logic [2:0]     out_channels_reg;
    logic           fifo_full;
    logic           fifo_empty;
    logic           fifo_push;
    logic           fifo_pop;
    qoid_pkg::cmd_t push_cmd;
    qoid_pkg::cmd_t head_cmd;
    qoid_pkg::res_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_channels_reg <= qoid_pkg::CH_RESET;
        else if (cfg_wr_en)
            out_channels_reg <= cfg_wr_data;
    end

    qoid_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .fifo_full     (fifo_full),
        .fifo_push     (fifo_push),
        .fifo_cmd      (push_cmd)
    );

    qoid_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (fifo_push),
        .wr_cmd     (push_cmd),
        .fifo_full  (fifo_full),
        .rd_en      (fifo_pop),
        .rd_cmd     (head_cmd),
        .fifo_empty (fifo_empty)
    );

    qoid_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .out_channels (out_channels_reg),
        .fifo_empty   (fifo_empty),
        .fifo_cmd     (head_cmd),
        .fifo_pop     (fifo_pop),
        .pop          (pop),
        .empty        (empty),
        .res          (res)
    );

    assign kind           = res.kind;
    assign red            = res.red;
    assign green          = res.green;
    assign blue           = res.blue;
    assign alpha          = res.alpha;
    assign last_of_run    = res.last_of_run;
    assign end_of_image   = res.end_of_image;
    assign header_ok      = res.header_ok;
    assign image_width    = res.image_width;
    assign image_height   = res.image_height;
    assign image_channels = res.image_channels;
    assign color_space    = res.color_space;

endmodule
